// ===== rtl/cqtf_pkg.sv =====
// ----------------------------------------------------------------------------
// cqtf_pkg
// Shared types and character codes for the comment and quote text filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cqtf_pkg;

  // Lexical mode of the filter. Codes 5 to 7 never arise and act as normal.
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SQUOTE = 3'd1,
    MODE_DQUOTE = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_LINE   = 3'd4
  } mode_t;

  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_LF        = 8'd10;
  localparam logic [7:0] CH_CR        = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_DQUOTE    = 8'd34;
  localparam logic [7:0] CH_SQUOTE    = 8'd39;
  localparam logic [7:0] CH_STAR      = 8'd42;
  localparam logic [7:0] CH_SLASH     = 8'd47;
  localparam logic [7:0] CH_BACKSLASH = 8'd92;

  // Lexer state carried from one input byte to the next.
  typedef struct packed {
    mode_t mode;
    logic  held_slash;
    logic  slash_may_open;
    logic  held_backslash;
    logic  prev_space;
    logic  prev_escape;
    logic  prev_star;
  } lex_state_t;

  // One queue entry: the one or two bytes that a single input byte causes.
  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       two;
  } run_entry_t;

endpackage : cqtf_pkg

`default_nettype wire

// ===== rtl/cqtf_front.sv =====
// ----------------------------------------------------------------------------
// cqtf_front
// Accepts raw bytes, runs the lexer and pushes the resulting byte runs.
// ----------------------------------------------------------------------------
`default_nettype none

module cqtf_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [7:0]           in_byte,
  input  wire logic                 q_full,
  output logic                      push,
  output cqtf_pkg::run_entry_t      push_entry
);
  import cqtf_pkg::*;

  lex_state_t st;
  lex_state_t st_next;
  logic       pre_en;
  logic [7:0] pre_byte;
  logic       main_en;
  logic       accept;

  assign accept = in_valid && !q_full;

  // A run is at most a released held character followed by one main byte.
  always_comb begin
    logic run_pn;
    logic run_pd;
    st_next  = st;
    pre_en   = 1'b0;
    pre_byte = CH_BACKSLASH;
    main_en  = 1'b0;
    run_pn   = 1'b0;
    run_pd   = 1'b0;
    unique case (st.mode)
      MODE_SQUOTE: begin
        main_en = 1'b1;
        if (in_byte == CH_SQUOTE) begin
          st_next.mode       = MODE_NORMAL;
          st_next.prev_space = 1'b0;
        end else if (in_byte == CH_LF) begin
          st_next.prev_space = 1'b1;
        end
      end
      MODE_DQUOTE: begin
        if (st.held_backslash) begin
          st_next.held_backslash = 1'b0;
          if (in_byte == CH_LF) begin
            st_next.prev_escape = 1'b0;
          end else begin
            pre_en              = 1'b1;
            pre_byte            = CH_BACKSLASH;
            st_next.prev_escape = 1'b1;
            run_pd              = 1'b1;
          end
        end else begin
          run_pd = 1'b1;
        end
      end
      MODE_BLOCK: begin
        priority if (in_byte == CH_LF) begin
          main_en           = 1'b1;
          st_next.prev_star = 1'b0;
        end else if (in_byte == CH_SLASH && st.prev_star) begin
          st_next.mode       = MODE_NORMAL;
          st_next.prev_star  = 1'b0;
          st_next.prev_space = 1'b0;
        end else begin
          st_next.prev_star = (in_byte == CH_STAR);
        end
      end
      MODE_LINE: begin
        if (in_byte == CH_LF) begin
          main_en            = 1'b1;
          st_next.mode       = MODE_NORMAL;
          st_next.prev_space = 1'b1;
        end
      end
      default: begin
        st_next.mode = MODE_NORMAL;
        priority if (st.held_backslash) begin
          st_next.held_backslash = 1'b0;
          if (in_byte == CH_LF) begin
            st_next.prev_space = 1'b1;
          end else begin
            pre_en   = 1'b1;
            pre_byte = CH_BACKSLASH;
            run_pn   = 1'b1;
          end
        end else if (st.held_slash) begin
          st_next.held_slash = 1'b0;
          priority if (in_byte == CH_STAR) begin
            pre_en             = 1'b1;
            pre_byte           = CH_SPACE;
            st_next.mode       = MODE_BLOCK;
            st_next.prev_star  = 1'b0;
            st_next.prev_space = 1'b0;
          end else if (in_byte == CH_SLASH && st.slash_may_open) begin
            st_next.mode = MODE_LINE;
          end else begin
            pre_en   = 1'b1;
            pre_byte = CH_SLASH;
            run_pn   = 1'b1;
          end
        end else begin
          run_pn = 1'b1;
        end
      end
    endcase

    // Plain handling of one byte in normal mode.
    if (run_pn) begin
      priority if (in_byte == CH_LF) begin
        main_en            = 1'b1;
        st_next.prev_space = 1'b1;
      end else if (in_byte == CH_SPACE || in_byte == CH_TAB) begin
        st_next.prev_space = 1'b1;
      end else if (in_byte == CH_DQUOTE) begin
        main_en             = 1'b1;
        st_next.mode        = MODE_DQUOTE;
        st_next.prev_escape = 1'b0;
        st_next.prev_space  = 1'b0;
      end else if (in_byte == CH_SQUOTE) begin
        main_en            = 1'b1;
        st_next.mode       = MODE_SQUOTE;
        st_next.prev_space = 1'b0;
      end else if (in_byte == CH_SLASH) begin
        st_next.held_slash     = 1'b1;
        st_next.slash_may_open = st_next.prev_space;
        st_next.prev_space     = 1'b0;
      end else if (in_byte == CH_BACKSLASH) begin
        st_next.held_backslash = 1'b1;
        st_next.prev_space     = 1'b0;
      end else begin
        main_en            = 1'b1;
        st_next.prev_space = (in_byte >= CH_TAB) && (in_byte <= CH_CR);
      end
    end

    // A slash released or consumed here never opens a line comment later.
    if (st.mode != MODE_SQUOTE && st.mode != MODE_DQUOTE && st.mode != MODE_BLOCK &&
        st.mode != MODE_LINE && !st.held_backslash && st.held_slash) begin
      st_next.slash_may_open = 1'b0;
    end

    // Plain handling of one byte inside double quotes.
    if (run_pd) begin
      priority if (in_byte == CH_LF) begin
        main_en             = 1'b1;
        st_next.prev_escape = 1'b0;
      end else if (in_byte == CH_BACKSLASH) begin
        st_next.held_backslash = 1'b1;
      end else if (in_byte == CH_DQUOTE) begin
        main_en = 1'b1;
        if (!st_next.prev_escape) begin
          st_next.mode       = MODE_NORMAL;
          st_next.prev_space = 1'b0;
        end
        st_next.prev_escape = 1'b0;
      end else begin
        main_en             = 1'b1;
        st_next.prev_escape = 1'b0;
      end
    end
  end

  always_comb begin
    push = accept && (pre_en || main_en);
    if (pre_en) begin
      push_entry.first_byte  = pre_byte;
      push_entry.second_byte = in_byte;
      push_entry.two         = main_en;
    end else begin
      push_entry.first_byte  = in_byte;
      push_entry.second_byte = in_byte;
      push_entry.two         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode           <= MODE_NORMAL;
      st.held_slash     <= 1'b0;
      st.slash_may_open <= 1'b0;
      st.held_backslash <= 1'b0;
      st.prev_space     <= 1'b1;
      st.prev_escape    <= 1'b0;
      st.prev_star      <= 1'b0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule : cqtf_front

`default_nettype wire

// ===== rtl/cqtf_queue.sv =====
// ----------------------------------------------------------------------------
// cqtf_queue
// Small first-in first-out queue of byte runs between lexer and output.
// ----------------------------------------------------------------------------
`default_nettype none

module cqtf_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire cqtf_pkg::run_entry_t push_entry,
  input  wire logic                 pop,
  output cqtf_pkg::run_entry_t      head,
  output logic                      not_empty,
  output logic                      full
);
  import cqtf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from an empty queue");

endmodule : cqtf_queue

`default_nettype wire

// ===== rtl/cqtf_back.sv =====
// ----------------------------------------------------------------------------
// cqtf_back
// Takes byte runs from the queue and sends them out one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cqtf_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cqtf_pkg::run_entry_t head,
  input  wire logic                 not_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_byte,
  output logic                      last_of_run
);
  import cqtf_pkg::*;

  run_entry_t cur;
  logic       phase;
  logic       taken;
  logic       advance;
  logic       free;

  assign taken   = out_valid && !out_stall;
  assign advance = taken && !phase && cur.two;
  assign free    = !out_valid || (taken && !advance);
  assign pop     = free && not_empty;

  assign out_byte    = phase ? cur.second_byte : cur.first_byte;
  assign last_of_run = phase || !cur.two;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (advance) begin
      phase <= 1'b1;
    end else if (free) begin
      out_valid <= not_empty;
      phase     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

endmodule : cqtf_back

`default_nettype wire

// ===== rtl/comment_quote_text_filter_core.sv =====
// ----------------------------------------------------------------------------
// comment_quote_text_filter_core
// Streaming filter that strips blanks and C comments while keeping quotes.
// ----------------------------------------------------------------------------
// Path: an input beat's first result is written into the queue when the beat
//   is accepted, then moved into the output register once that is free.
// Throughput: one input beat per cycle while the queue is not full, and one
//   output beat per cycle while out_stall is low; two results take two beats.
// Reset: synchronous, active high; the lexer returns to normal mode at the
//   start of a line and the queue and output register are emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module comment_quote_text_filter_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            last_of_run
);
  import cqtf_pkg::*;

  // The front part holds the lexer state and turns every accepted byte
  // into a run of zero, one or two output bytes. A held slash or
  // backslash, when released, is the first byte of the following run.
  // Runs with no bytes never enter the queue.
  run_entry_t push_entry;
  run_entry_t head;
  logic       push;
  logic       pop;
  logic       not_empty;
  logic       q_full;

  // The input stalls only when the queue is full, so the lexer keeps
  // taking bytes while the output side waits on its receiver.
  assign in_stall = q_full;

  cqtf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // The queue decouples the lexer from the output so that each side can
  // stall on its own.
  cqtf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (q_full)
  );

  // The back part presents each run one beat at a time from a register
  // and marks the final beat of the run with last_of_run.
  cqtf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .not_empty   (not_empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule : comment_quote_text_filter_core

`default_nettype wire

// ===== tb/sv/text_filter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_filter_checker
// Watches both channels of the comment and quote text filter. It predicts the
// filtered bytes of every accepted input beat and compares them with the output beats.
// ----------------------------------------------------------------------------

module text_filter_checker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [7:0] out_byte,
  input  wire logic       last_of_run,
  output int              fail_count,
  output int              pending
);
  import cqtf_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } filtered_t;

  // Lexer state of the prediction.
  mode_t lex_mode;
  bit    slash_held;
  bit    slash_opens;
  bit    bsl_held;
  bit    after_space;
  bit    after_escape;
  bit    after_star;

  logic [7:0] run_bytes[$];
  filtered_t  filtered_q[$];
  int         errors;

  function automatic void push_run(input logic [7:0] b);
    if (run_bytes.size() < 2) begin
      run_bytes.insert(run_bytes.size(), b);
    end
  endfunction

  function automatic void normal_plain(input logic [7:0] b);
    if (b == CH_LF) begin
      push_run(b);
      after_space = 1'b1;
    end else if (b == CH_SPACE || b == CH_TAB) begin
      after_space = 1'b1;
    end else if (b == CH_DQUOTE) begin
      push_run(b);
      lex_mode     = MODE_DQUOTE;
      after_escape = 1'b0;
      after_space  = 1'b0;
    end else if (b == CH_SQUOTE) begin
      push_run(b);
      lex_mode    = MODE_SQUOTE;
      after_space = 1'b0;
    end else if (b == CH_SLASH) begin
      slash_held  = 1'b1;
      slash_opens = after_space;
      after_space = 1'b0;
    end else if (b == CH_BACKSLASH) begin
      bsl_held    = 1'b1;
      after_space = 1'b0;
    end else begin
      push_run(b);
      after_space = (b >= CH_TAB && b <= CH_CR);
    end
  endfunction

  function automatic void dquote_plain(input logic [7:0] b);
    if (b == CH_LF) begin
      push_run(b);
      after_escape = 1'b0;
    end else if (b == CH_BACKSLASH) begin
      bsl_held = 1'b1;
    end else if (b == CH_DQUOTE) begin
      push_run(b);
      if (!after_escape) begin
        lex_mode    = MODE_NORMAL;
        after_space = 1'b0;
      end
      after_escape = 1'b0;
    end else begin
      push_run(b);
      after_escape = 1'b0;
    end
  endfunction

  // Works out the filtered bytes of one input byte and queues them.
  function automatic void filter_byte(input logic [7:0] b);
    filtered_t f;
    int        i;
    run_bytes.delete();
    case (lex_mode)
      MODE_SQUOTE: begin
        push_run(b);
        if (b == CH_SQUOTE) begin
          lex_mode    = MODE_NORMAL;
          after_space = 1'b0;
        end else if (b == CH_LF) begin
          after_space = 1'b1;
        end
      end
      MODE_DQUOTE: begin
        if (bsl_held) begin
          bsl_held = 1'b0;
          if (b == CH_LF) begin
            after_escape = 1'b0;
          end else begin
            push_run(CH_BACKSLASH);
            after_escape = 1'b1;
            dquote_plain(b);
          end
        end else begin
          dquote_plain(b);
        end
      end
      MODE_BLOCK: begin
        if (b == CH_LF) begin
          push_run(b);
          after_star = 1'b0;
        end else if (b == CH_SLASH && after_star) begin
          lex_mode    = MODE_NORMAL;
          after_star  = 1'b0;
          after_space = 1'b0;
        end else begin
          after_star = (b == CH_STAR);
        end
      end
      MODE_LINE: begin
        if (b == CH_LF) begin
          push_run(b);
          lex_mode    = MODE_NORMAL;
          after_space = 1'b1;
        end
      end
      default: begin
        lex_mode = MODE_NORMAL;
        if (bsl_held) begin
          bsl_held = 1'b0;
          if (b == CH_LF) begin
            after_space = 1'b1;
          end else begin
            push_run(CH_BACKSLASH);
            normal_plain(b);
          end
        end else if (slash_held) begin
          slash_held = 1'b0;
          if (b == CH_STAR) begin
            push_run(CH_SPACE);
            lex_mode    = MODE_BLOCK;
            after_star  = 1'b0;
            after_space = 1'b0;
          end else if (b == CH_SLASH && slash_opens) begin
            lex_mode = MODE_LINE;
          end else begin
            push_run(CH_SLASH);
            normal_plain(b);
          end
          slash_opens = 1'b0;
        end else begin
          normal_plain(b);
        end
      end
    endcase
    for (i = 0; i < run_bytes.size(); i++) begin
      f.ch   = run_bytes[i];
      f.last = (i == run_bytes.size() - 1);
      filtered_q.insert(filtered_q.size(), f);
    end
  endfunction

  always @(posedge clk) begin
    filtered_t want;
    if (rst) begin
      lex_mode     = MODE_NORMAL;
      slash_held   = 1'b0;
      slash_opens  = 1'b0;
      bsl_held     = 1'b0;
      after_space  = 1'b1;
      after_escape = 1'b0;
      after_star   = 1'b0;
      filtered_q.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall) begin
        filter_byte(in_byte);
      end
      if (out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected beat: expected none, actual out_byte %h last_of_run %b",
                   $time, out_byte, last_of_run);
          errors++;
        end else begin
          want = filtered_q.pop_front();
          if (out_byte !== want.ch) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want.ch, out_byte);
            errors++;
          end
          if (last_of_run !== want.last) begin
            $display("%0t: last_of_run mismatch: expected %b, actual %b",
                     $time, want.last, last_of_run);
            errors++;
          end
        end
      end
    end
    fail_count <= errors;
    pending    <= filtered_q.size();
  end

endmodule : text_filter_checker

// ===== tb/sv/tb_comment_quote_text_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_comment_quote_text_filter_core
// Drives the text filter with a short directed byte stream and then with
// random C-like text: identifiers, blanks, block and line comments, quoted
// strings, line joins and raw bytes. Both sides idle at random. The checker
// beside the block predicts and compares every output beat.
// ----------------------------------------------------------------------------

module tb_comment_quote_text_filter_core;
  import cqtf_pkg::*;

  // Stream sizes and run control.
  localparam int TEXT_BYTES  = 2000;
  localparam int IDLE_PCT    = 37;
  localparam int PRESSURE_AT = 300;
  localparam int HOLD_CYCLES = 60;
  localparam int STEADY_LO   = 1000;
  localparam int STEADY_HI   = 1300;
  localparam int TAIL_CYCLES = 8;
  localparam int LIMIT       = 200000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       last_of_run;

  int fail_count;
  int pending;
  int cycles = 0;

  // Beats accepted so far; the receiver keys its hold-off and the quiet
  // stretch off this count.
  int beats_sent = 0;
  bit pressure_on = 1'b0;
  bit pressure_done = 1'b0;
  bit steady;

  logic [7:0] text_q[$];

  assign steady = (beats_sent >= STEADY_LO) && (beats_sent < STEADY_HI);

  initial begin
    forever begin
      #10 clk = ~clk;
    end
  end

  comment_quote_text_filter_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

  text_filter_checker u_filter_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Hard stop in case the block hangs or stalls forever.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb_comment_quote_text_filter_core failed");
      $finish;
    end
  end

  // Receiver. It stalls at random except in the quiet stretch. Once, it holds
  // off for a long stretch while the sender keeps offering beats, so the
  // block's queue fills and it has to stall its input.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (!pressure_done && beats_sent >= PRESSURE_AT) begin
        pressure_on = 1'b1;
        out_stall <= 1'b1;
        for (hold = 0; hold < HOLD_CYCLES; hold++) begin
          @(posedge clk);
        end
        pressure_on   = 1'b0;
        pressure_done = 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  function automatic logic [7:0] pick(input logic [7:0] a, b, c, d);
    case ($urandom_range(3))
      0:       pick = a;
      1:       pick = b;
      2:       pick = c;
      default: pick = d;
    endcase
  endfunction

  // Appends one byte to the end of the text stream.
  function automatic void add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // Appends one random piece of text. Most pieces are well-formed lexical
  // units with random content so that every mode is reached; the rest are
  // raw bytes and stray slashes or backslashes.
  task automatic add_token();
    int         kind;
    int         n;
    int         i;
    logic [7:0] rb;
    kind = $urandom_range(99);
    if (kind < 25) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) begin
        rb = 8'($urandom_range(48, 122));
        add_byte(rb);
      end
    end else if (kind < 37) begin
      // Blanks, including the vertical tab, form feed and carriage return
      // that pass through but still count as whitespace.
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
        rb = 8'($urandom_range(11, 13));
        add_byte(pick(CH_SPACE, CH_TAB, CH_SPACE, rb));
      end
    end else if (kind < 47) begin
      add_byte(CH_LF);
    end else if (kind < 57) begin
      // Block comment; stray stars, slashes and line ends inside it, and
      // now and then no closing pair at all.
      add_byte(CH_SLASH);
      add_byte(CH_STAR);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        add_byte(pick(CH_STAR, CH_SLASH, CH_LF, "q"));
      end
      if ($urandom_range(9) != 0) begin
        add_byte(CH_STAR);
        add_byte(CH_SLASH);
      end
    end else if (kind < 64) begin
      // Line comment after whitespace or at the start of a line; a
      // backslash right before its line end must not join lines.
      add_byte(pick(CH_SPACE, CH_TAB, CH_LF, CH_SPACE));
      add_byte(CH_SLASH);
      add_byte(CH_SLASH);
      n = $urandom_range(0, 5);
      for (i = 0; i < n; i++) begin
        add_byte(pick("c", CH_BACKSLASH, CH_DQUOTE, CH_STAR));
      end
      add_byte(CH_LF);
    end else if (kind < 74) begin
      // Double-quoted text with escapes, escaped quotes and line ends.
      add_byte(CH_DQUOTE);
      n = $urandom_range(0, 6);
      for (i = 0; i < n; i++) begin
        add_byte(pick("s", CH_BACKSLASH, CH_DQUOTE,
                      pick(CH_LF, CH_SPACE, CH_SQUOTE, CH_TAB)));
      end
      add_byte(CH_DQUOTE);
    end else if (kind < 80) begin
      add_byte(CH_SQUOTE);
      n = $urandom_range(0, 3);
      for (i = 0; i < n; i++) begin
        add_byte(pick("k", CH_BACKSLASH, CH_SPACE, CH_DQUOTE));
      end
      add_byte(CH_SQUOTE);
    end else if (kind < 86) begin
      add_byte(CH_BACKSLASH);
      add_byte(pick(CH_LF, CH_LF, "n", CH_BACKSLASH));
    end else if (kind < 92) begin
      add_byte(CH_SLASH);
      add_byte(pick("x", CH_SLASH, CH_STAR, CH_SPACE));
    end else begin
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) begin
        rb = 8'($urandom_range(255));
        add_byte(rb);
      end
    end
  endtask

  // Offers one beat and returns once it is accepted. Random idle cycles go
  // before the beat, except while the receiver holds off or in the quiet
  // stretch. in_valid stays high between back-to-back beats.
  task automatic send_byte(input logic [7:0] b);
    while (!pressure_on && !steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    beats_sent++;
  endtask

  initial begin
    logic [7:0] directed[];
    int         i;

    // Directed opening: byte extremes, a block comment spanning a line end,
    // the slash after a comment's close that must not open a line comment,
    // a line comment ended by a backslash and line end, an escaped quote,
    // an unterminated string joined across lines, a quote as first byte of
    // the next line, single quotes holding a double quote, a carriage
    // return, and a line join in normal mode.
    directed = '{8'h00, 8'hFF, CH_SPACE, CH_SLASH, CH_STAR, CH_LF, CH_STAR,
                 CH_SLASH, CH_SLASH, CH_SLASH, CH_TAB, CH_SLASH, CH_SLASH,
                 CH_BACKSLASH, CH_LF, CH_DQUOTE, CH_BACKSLASH, CH_DQUOTE,
                 CH_LF, CH_BACKSLASH, CH_LF, CH_DQUOTE, CH_SQUOTE, CH_DQUOTE,
                 CH_SQUOTE, CH_CR, CH_BACKSLASH, CH_LF};
    for (i = 0; i < directed.size(); i++) begin
      add_byte(directed[i]);
    end
    while (text_q.size() < directed.size() + TEXT_BYTES) begin
      add_token();
    end

    // Reset is applied once, before any byte is sent.
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (text_q.size() > 0) begin
      send_byte(text_q.pop_front());
    end
    in_valid <= 1'b0;

    // Drain: an edge first lets the checker's count take in the last beat; then
    // wait for every predicted beat, and a tail of TAIL_CYCLES more so that a
    // stray extra beat would still show up.
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("tb_comment_quote_text_filter_core passed");
    end else begin
      $display("tb_comment_quote_text_filter_core failed");
    end
    $finish;
  end

endmodule : tb_comment_quote_text_filter_core

// ===== sim.f =====
rtl/cqtf_pkg.sv
rtl/cqtf_front.sv
rtl/cqtf_queue.sv
rtl/cqtf_back.sv
rtl/comment_quote_text_filter_core.sv
tb/sv/text_filter_checker.sv
tb/sv/tb_comment_quote_text_filter_core.sv
